// ===== rtl/gxy_pkg.sv =====
// Shared types and constants of the G-code X/Y move parser.
`timescale 1ns / 1ps
package gxy_pkg;

    localparam int STEP_BITS = 18;
    localparam logic [STEP_BITS-1:0] STEP_MAX = 18'h3FFFF;
    localparam logic [7:0] SPM_RESET = 8'd25;

    localparam int JOB_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    localparam logic [1:0] KIND_X   = 2'd0;
    localparam logic [1:0] KIND_Y   = 2'd1;
    localparam logic [1:0] KIND_PEN = 2'd2;

    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [3:0] ROUND_DIGIT = 4'd5;

    // Job handed from the parser to the move unit
    typedef struct packed {
        logic is_pen;
        logic pen_down;
        logic x_arm;
        logic y_arm;
    } t_job_ctl;

    // One finished result
    typedef struct packed {
        logic [1:0]           kind;
        logic                 neg;
        logic [STEP_BITS-1:0] steps;
        logic                 pen_down;
        logic                 last;
    } t_res;

endpackage

// ===== rtl/gxy_fifo.sv =====
// Small register-based queue used between the parser, the move unit and the output.
`timescale 1ns / 1ps
module gxy_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty,
    output logic [$clog2(DEPTH):0] o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH) + 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr, n_wptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_ok, rd_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_rdata = r_mem[r_rptr];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (wr_ok) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (rd_ok) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (wr_ok && !rd_ok) begin
            n_count = r_count + 1'b1;
        end else if (rd_ok && !wr_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

// ===== rtl/gxy_front.sv =====
// Character parser: arms axes, builds coordinates and issues move and pen jobs.
`timescale 1ns / 1ps
module gxy_front
    import gxy_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_text_char,
    input  logic                  i_end_of_text,
    output logic                  o_job_push,
    output t_job_ctl              o_job_ctl,
    output logic [COORD_BITS-1:0] o_x_target,
    output logic [COORD_BITS-1:0] o_y_target
);

    localparam int CB = COORD_BITS;

    logic          r_x_arm, r_y_arm, r_pen_arm, r_in_frac, r_frac_seen;
    logic          n_x_arm, n_y_arm, n_pen_arm, n_in_frac, n_frac_seen;
    logic          r_x_up, r_y_up, n_x_up, n_y_up;
    logic [CB-1:0] r_x_whole, r_y_whole, n_x_whole, n_y_whole;

    logic [3:0]    digit;
    logic [CB+3:0] x_ext, y_ext, x_acc, y_acc;
    logic [CB-1:0] x_acc_sat, y_acc_sat;
    logic [CB:0]   x_sum, y_sum;

    assign digit = 4'(i_text_char - CH_0);
    assign x_ext = {4'b0, r_x_whole};
    assign y_ext = {4'b0, r_y_whole};
    // acc * 10 + digit, as two shifts and two adds
    assign x_acc = (x_ext << 3) + (x_ext << 1) + {{CB{1'b0}}, digit};
    assign y_acc = (y_ext << 3) + (y_ext << 1) + {{CB{1'b0}}, digit};
    assign x_acc_sat = (|x_acc[CB+3:CB]) ? '1 : x_acc[CB-1:0];
    assign y_acc_sat = (|y_acc[CB+3:CB]) ? '1 : y_acc[CB-1:0];

    assign x_sum = {1'b0, r_x_whole} + (CB+1)'(r_x_up);
    assign y_sum = {1'b0, r_y_whole} + (CB+1)'(r_y_up);
    assign o_x_target = x_sum[CB] ? '1 : x_sum[CB-1:0];
    assign o_y_target = y_sum[CB] ? '1 : y_sum[CB-1:0];

    always_comb begin
        n_x_arm     = r_x_arm;
        n_y_arm     = r_y_arm;
        n_pen_arm   = r_pen_arm;
        n_in_frac   = r_in_frac;
        n_frac_seen = r_frac_seen;
        n_x_up      = r_x_up;
        n_y_up      = r_y_up;
        n_x_whole   = r_x_whole;
        n_y_whole   = r_y_whole;
        o_job_push  = 1'b0;
        o_job_ctl   = '0;
        o_job_ctl.x_arm = r_x_arm;
        o_job_ctl.y_arm = r_y_arm;

        if (i_accept) begin
            case (i_text_char)
                CH_X: begin
                    n_x_arm = 1'b1;
                end
                CH_Y: begin
                    n_y_arm = 1'b1;
                end
                CH_Z: begin
                    n_pen_arm = 1'b1;
                end
                CH_DOT: begin
                    n_in_frac = 1'b1;
                end
                CH_SPACE, CH_SEMI: begin
                    // close the field: hand the armed targets to the move unit
                    o_job_push  = r_x_arm || r_y_arm;
                    n_x_arm     = 1'b0;
                    n_y_arm     = 1'b0;
                    n_in_frac   = 1'b0;
                    n_frac_seen = 1'b0;
                    n_x_whole   = '0;
                    n_y_whole   = '0;
                    n_x_up      = 1'b0;
                    n_y_up      = 1'b0;
                end
                default: begin
                    if (r_pen_arm && (i_text_char == CH_2 || i_text_char == CH_3)) begin
                        o_job_push         = 1'b1;
                        o_job_ctl.is_pen   = 1'b1;
                        o_job_ctl.pen_down = (i_text_char == CH_3);
                        o_job_ctl.x_arm    = 1'b0;
                        o_job_ctl.y_arm    = 1'b0;
                        n_pen_arm          = 1'b0;
                    end else if (i_text_char inside {[CH_0:CH_9]}) begin
                        if (!r_in_frac) begin
                            if (r_x_arm) begin
                                n_x_whole = x_acc_sat;
                            end
                            if (r_y_arm) begin
                                n_y_whole = y_acc_sat;
                            end
                        end else if (!r_frac_seen) begin
                            // only the first fraction digit rounds
                            n_frac_seen = 1'b1;
                            if (r_x_arm) begin
                                n_x_up = (digit >= ROUND_DIGIT);
                            end else if (r_y_arm) begin
                                n_y_up = (digit >= ROUND_DIGIT);
                            end
                        end
                    end
                end
            endcase

            if (i_end_of_text) begin
                n_x_arm     = 1'b0;
                n_y_arm     = 1'b0;
                n_pen_arm   = 1'b0;
                n_in_frac   = 1'b0;
                n_frac_seen = 1'b0;
                n_x_whole   = '0;
                n_y_whole   = '0;
                n_x_up      = 1'b0;
                n_y_up      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_arm     <= 1'b0;
            r_y_arm     <= 1'b0;
            r_pen_arm   <= 1'b0;
            r_in_frac   <= 1'b0;
            r_frac_seen <= 1'b0;
            r_x_up      <= 1'b0;
            r_y_up      <= 1'b0;
            r_x_whole   <= '0;
            r_y_whole   <= '0;
        end else begin
            r_x_arm     <= n_x_arm;
            r_y_arm     <= n_y_arm;
            r_pen_arm   <= n_pen_arm;
            r_in_frac   <= n_in_frac;
            r_frac_seen <= n_frac_seen;
            r_x_up      <= n_x_up;
            r_y_up      <= n_y_up;
            r_x_whole   <= n_x_whole;
            r_y_whole   <= n_y_whole;
        end
    end

endmodule

// ===== rtl/gxy_back.sv =====
// Move unit: tracks positions, computes step counts and writes results.
`timescale 1ns / 1ps
module gxy_back
    import gxy_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [7:0]            i_cfg_wr_data,
    input  logic                  i_job_empty,
    input  t_job_ctl              i_job_ctl,
    input  logic [COORD_BITS-1:0] i_x_target,
    input  logic [COORD_BITS-1:0] i_y_target,
    output logic                  o_job_pop,
    input  logic [$clog2(RES_DEPTH):0] i_res_count,
    output logic                  o_res_push,
    output t_res                  o_res
);

    localparam int CB = COORD_BITS;
    localparam int PW = CB + 8;
    localparam int WW = (PW + 1 > STEP_BITS + 1) ? PW + 1 : STEP_BITS + 1;
    localparam int RCW = $clog2(RES_DEPTH) + 1;

    logic [7:0]    r_spm;
    logic [CB-1:0] r_cur_x, r_cur_y;
    logic          r_px, r_py, r_pp, n_px, n_py, n_pp;
    logic [CB-1:0] r_dx, r_dy;
    logic          r_nx, r_ny, r_pen_down;

    logic          r_m_valid;
    logic [PW-1:0] r_m_prod;
    logic [1:0]    r_m_kind;
    logic          r_m_neg, r_m_pen_down, r_m_last;

    logic          issue, room;
    logic [CB-1:0] sel_dist;
    logic [1:0]    sel_kind;
    logic          sel_neg, sel_last;
    logic          x_go, y_go;
    logic [WW-1:0] rounded;

    // one result in flight in the product register counts against the queue
    assign room  = ({1'b0, i_res_count} + (RCW+1)'(r_m_valid)) < (RCW+1)'(RES_DEPTH);
    assign issue = (r_pp || r_px || r_py) && room;
    assign o_job_pop = !i_job_empty &&
                       (!(r_pp || r_px || r_py) || (issue && !(r_px && r_py)));

    assign x_go = i_job_ctl.x_arm && (i_x_target != r_cur_x);
    assign y_go = i_job_ctl.y_arm && (i_y_target != r_cur_y);

    always_comb begin
        if (r_pp) begin
            sel_dist = '0;
            sel_kind = KIND_PEN;
            sel_neg  = 1'b0;
            sel_last = 1'b1;
        end else if (r_px) begin
            sel_dist = r_dx;
            sel_kind = KIND_X;
            sel_neg  = r_nx;
            sel_last = !r_py;
        end else begin
            sel_dist = r_dy;
            sel_kind = KIND_Y;
            sel_neg  = r_ny;
            sel_last = 1'b1;
        end
    end

    always_comb begin
        n_px = r_px;
        n_py = r_py;
        n_pp = r_pp;
        if (issue) begin
            if (r_pp) begin
                n_pp = 1'b0;
            end else if (r_px) begin
                n_px = 1'b0;
            end else begin
                n_py = 1'b0;
            end
        end
        if (o_job_pop) begin
            n_pp = i_job_ctl.is_pen;
            n_px = x_go;
            n_py = y_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm     <= SPM_RESET;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_px      <= 1'b0;
            r_py      <= 1'b0;
            r_pp      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_spm <= i_cfg_wr_data;
            end
            r_px      <= n_px;
            r_py      <= n_py;
            r_pp      <= n_pp;
            r_m_valid <= issue;
            // the position becomes the target as soon as the job is taken
            if (o_job_pop && i_job_ctl.x_arm) begin
                r_cur_x <= i_x_target;
            end
            if (o_job_pop && i_job_ctl.y_arm) begin
                r_cur_y <= i_y_target;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_nx       <= (i_x_target < r_cur_x);
            r_ny       <= (i_y_target < r_cur_y);
            r_dx       <= (i_x_target < r_cur_x) ? r_cur_x - i_x_target
                                                 : i_x_target - r_cur_x;
            r_dy       <= (i_y_target < r_cur_y) ? r_cur_y - i_y_target
                                                 : i_y_target - r_cur_y;
            r_pen_down <= i_job_ctl.pen_down;
        end
        if (issue) begin
            r_m_prod     <= PW'(sel_dist) * PW'(r_spm);
            r_m_kind     <= sel_kind;
            r_m_neg      <= sel_neg;
            r_m_pen_down <= r_pp && r_pen_down;
            r_m_last     <= sel_last;
        end
    end

    // quarter steps to whole steps, rounding up, then saturate
    assign rounded = (WW'(r_m_prod) + WW'(3)) >> 2;

    always_comb begin
        o_res_push     = r_m_valid;
        o_res.kind     = r_m_kind;
        o_res.neg      = r_m_neg;
        o_res.pen_down = r_m_pen_down;
        o_res.last     = r_m_last;
        if (rounded > WW'(STEP_MAX)) begin
            o_res.steps = STEP_MAX;
        end else begin
            o_res.steps = rounded[STEP_BITS-1:0];
        end
    end

endmodule

// ===== rtl/gcode_xy_move_parser.sv =====
// Top level of the G-code X/Y move parser: parser, job queue, move unit, result queue.
// A closing character pushes its job into the job queue; the move unit pops it and
// issues each result, x before y, through the product register into the result queue.
// Throughput: one character per cycle while the job queue has room; the move unit's
// shared step multiplier gives one result per cycle while the result queue has room.
// Reset (i_rst_n low at a clock edge) empties both queues, clears the parse state and
// the positions, and loads 25 into the step rate register.
`timescale 1ns / 1ps
module gcode_xy_move_parser
    import gxy_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_char,
    input  logic        i_end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_command_kind,
    output logic        o_move_negative,
    output logic [17:0] o_step_count,
    output logic        o_pen_down,
    output logic        o_last_of_run,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);

    localparam int JW = $bits(t_job_ctl) + 2 * COORD_BITS;
    localparam int RW = $bits(t_res);

    logic                  accept;
    logic                  job_push, job_pop, job_empty;
    t_job_ctl              job_ctl_w, job_ctl_r;
    logic [COORD_BITS-1:0] x_tgt_w, y_tgt_w, x_tgt_r, y_tgt_r;
    logic [JW-1:0]         job_wdata, job_rdata;
    logic                  res_push;
    t_res                  res_w, res_r;
    logic [$clog2(RES_DEPTH):0] res_count;

    assign accept = push && !full;

    gxy_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_text_char   (i_text_char),
        .i_end_of_text (i_end_of_text),
        .o_job_push    (job_push),
        .o_job_ctl     (job_ctl_w),
        .o_x_target    (x_tgt_w),
        .o_y_target    (y_tgt_w)
    );

    assign job_wdata = {job_ctl_w, x_tgt_w, y_tgt_w};
    assign {job_ctl_r, x_tgt_r, y_tgt_r} = job_rdata;

    gxy_fifo #(.WIDTH(JW), .DEPTH(JOB_DEPTH)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_push),
        .i_wdata (job_wdata),
        .i_rd    (job_pop),
        .o_rdata (job_rdata),
        .o_full  (full),
        .o_empty (job_empty),
        .o_count ()
    );

    gxy_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_job_empty   (job_empty),
        .i_job_ctl     (job_ctl_r),
        .i_x_target    (x_tgt_r),
        .i_y_target    (y_tgt_r),
        .o_job_pop     (job_pop),
        .i_res_count   (res_count),
        .o_res_push    (res_push),
        .o_res         (res_w)
    );

    gxy_fifo #(.WIDTH(RW), .DEPTH(RES_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (res_w),
        .i_rd    (pop),
        .o_rdata (res_r),
        .o_full  (),
        .o_empty (empty),
        .o_count (res_count)
    );

    assign o_command_kind  = res_r.kind;
    assign o_move_negative = res_r.neg;
    assign o_step_count    = res_r.steps;
    assign o_pen_down      = res_r.pen_down;
    assign o_last_of_run   = res_r.last;

endmodule

// ===== rtl/gxy_checker.sv =====
// Port-level checks on the G-code X/Y move parser, bound to its top level.
`timescale 1ns / 1ps
module gxy_checker
    import gxy_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_command_kind,
    input logic        o_move_negative,
    input logic [17:0] o_step_count,
    input logic        o_pen_down,
    input logic        o_last_of_run
);

    // reset leaves nothing waiting and room for input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not clear after reset");

    // a pen command carries no motion
    a_pen_no_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_command_kind == KIND_PEN) |-> (o_step_count == '0 && !o_move_negative
            && o_last_of_run))
        else $error("pen command with motion fields set");

    // an axis move never lowers the pen and is of a known kind
    a_axis_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_command_kind != KIND_PEN) |-> (!o_pen_down
            && (o_command_kind == KIND_X || o_command_kind == KIND_Y)))
        else $error("bad axis result");

    // an x move that is not the last of its run is followed at once by the y move
    a_x_then_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_command_kind == KIND_X && !o_last_of_run)
            |=> (!empty && o_command_kind == KIND_Y))
        else $error("y move missing after x move");

    // a waiting result holds until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_command_kind) && $stable(o_step_count)
            && $stable(o_last_of_run)))
        else $error("result changed before transfer");

endmodule

bind gcode_xy_move_parser gxy_checker u_gxy_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_command_kind  (o_command_kind),
    .o_move_negative (o_move_negative),
    .o_step_count    (o_step_count),
    .o_pen_down      (o_pen_down),
    .o_last_of_run   (o_last_of_run)
);

// ===== bench/testbench.sv =====
// Self-checking testbench for the G-code X/Y move parser: predicts each move from the text stream.
`timescale 1ns / 1ps
module testbench;
    import gxy_pkg::*;

    localparam int COORD_W = 12;
    localparam int unsigned COORD_MAX = (1 << COORD_W) - 1;

    // Predicts moves and pen commands from the character stream and checks what comes out
    class xy_move_book;
        logic [7:0] rate;
        bit x_arm, y_arm, pen_arm, in_frac, frac_seen, x_up, y_up;
        int unsigned x_acc, y_acc, x_pos, y_pos;
        t_res moves_due[$];
        int errors;

        function new();
            rate = SPM_RESET;
            errors = 0;
            x_pos = 0;
            y_pos = 0;
            pen_arm = 0;
            clear_field();
        endfunction

        function void clear_field();
            x_arm = 0;
            y_arm = 0;
            in_frac = 0;
            frac_seen = 0;
            x_acc = 0;
            y_acc = 0;
            x_up = 0;
            y_up = 0;
        endfunction

        function int unsigned add_digit(int unsigned acc, int unsigned d);
            int unsigned v;
            v = acc * 10 + d;
            return (v > COORD_MAX) ? COORD_MAX : v;
        endfunction

        // Returns 1 with the move in mv when the axis actually has to travel
        function bit axis_move(input logic [1:0] kind, input int unsigned whole, input bit up,
                               inout int unsigned pos, output t_res mv);
            int unsigned target;
            int unsigned travel;
            logic [63:0] steps;
            mv = '0;
            target = whole + up;
            if (target > COORD_MAX) target = COORD_MAX;
            if (target == pos) return 0;
            mv.kind = kind;
            if (target > pos) begin
                travel = target - pos;
                mv.neg = 1'b0;
            end else begin
                travel = pos - target;
                mv.neg = 1'b1;
            end
            steps = (64'(travel) * 64'(rate) + 64'd3) >> 2;
            mv.steps = (steps > 64'(STEP_MAX)) ? STEP_MAX : steps[STEP_BITS-1:0];
            pos = target;
            return 1;
        endfunction

        function void note_char(logic [7:0] c, logic eot);
            t_res run[$];
            t_res mv;
            int unsigned d;
            if (c == CH_X) begin
                x_arm = 1;
            end else if (c == CH_Y) begin
                y_arm = 1;
            end else if (c == CH_Z) begin
                pen_arm = 1;
            end else if ((c == CH_2 || c == CH_3) && pen_arm) begin
                mv = '0;
                mv.kind = KIND_PEN;
                mv.pen_down = (c == CH_3);
                run.push_back(mv);
                pen_arm = 0;
            end else if (c == CH_DOT) begin
                in_frac = 1;
            end else if (c >= CH_0 && c <= CH_9) begin
                d = 32'(c) - 32'(CH_0);
                if (!in_frac) begin
                    if (x_arm) x_acc = add_digit(x_acc, d);
                    if (y_arm) y_acc = add_digit(y_acc, d);
                end else if (!frac_seen) begin
                    // only the first fraction digit rounds, and x takes it first
                    frac_seen = 1;
                    if (x_arm) x_up = (d >= ROUND_DIGIT);
                    else if (y_arm) y_up = (d >= ROUND_DIGIT);
                end
            end else if (c == CH_SPACE || c == CH_SEMI) begin
                if (x_arm) begin
                    if (axis_move(KIND_X, x_acc, x_up, x_pos, mv)) run.push_back(mv);
                end
                if (y_arm) begin
                    if (axis_move(KIND_Y, y_acc, y_up, y_pos, mv)) run.push_back(mv);
                end
                clear_field();
            end
            if (run.size() > 0) run[run.size()-1].last = 1'b1;
            foreach (run[i]) moves_due.push_back(run[i]);
            if (eot) begin
                clear_field();
                pen_arm = 0;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_move(t_res got);
            t_res want;
            if (moves_due.size() == 0) begin
                $error("result with nothing due: kind %0d, steps %0d", got.kind, got.steps);
                errors++;
                return;
            end
            want = moves_due.pop_front();
            compare_field("command_kind", 32'(want.kind), 32'(got.kind));
            compare_field("move_negative", 32'(want.neg), 32'(got.neg));
            compare_field("step_count", 32'(want.steps), 32'(got.steps));
            compare_field("pen_down", 32'(want.pen_down), 32'(got.pen_down));
            compare_field("last_of_run", 32'(want.last), 32'(got.last));
        endfunction

        function int pending();
            return moves_due.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_text_char;
    logic        i_end_of_text;
    logic        empty;
    logic        pop;
    logic [1:0]  o_command_kind;
    logic        o_move_negative;
    logic [17:0] o_step_count;
    logic        o_pen_down;
    logic        o_last_of_run;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;

    xy_move_book book;
    int tx_idle_pct = 32;
    int rx_idle_pct = 32;
    int chars_sent = 0;

    gcode_xy_move_parser #(
        .COORD_BITS (COORD_W)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_text_char     (i_text_char),
        .i_end_of_text   (i_end_of_text),
        .empty           (empty),
        .pop             (pop),
        .o_command_kind  (o_command_kind),
        .o_move_negative (o_move_negative),
        .o_step_count    (o_step_count),
        .o_pen_down      (o_pen_down),
        .o_last_of_run   (o_last_of_run),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("gcode_xy_move_parser verification failed");
        $finish;
    end

    task automatic send_char(logic [7:0] c, logic eot);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_text_char <= c;
        i_end_of_text <= eot;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        book.note_char(c, eot);
        chars_sent++;
    endtask

    task automatic send_str(string s, bit eot_at_end);
        for (int i = 0; i < s.len(); i++) send_char(s[i], eot_at_end && (i == s.len() - 1));
    endtask

    task automatic send_digit(logic eot);
        send_char(CH_0 + 8'($urandom_range(9)), eot);
    endtask

    // Axis letters, whole part, optional fraction, then a terminator (or the text ends early)
    task automatic send_axis_field();
        int axes;
        int n_int;
        bit early;
        axes = $urandom_range(3);
        early = ($urandom_range(19) == 0);
        case (axes)
            0: send_char(CH_X, 1'b0);
            1: send_char(CH_Y, 1'b0);
            2: begin
                send_char(CH_X, 1'b0);
                send_char(CH_Y, 1'b0);
            end
            default: begin
                send_char(CH_Y, 1'b0);
                send_char(CH_X, 1'b0);
            end
        endcase
        n_int = ($urandom_range(9) == 0) ? $urandom_range(4, 5) : $urandom_range(0, 3);
        repeat (n_int) send_digit(1'b0);
        if ($urandom_range(1)) begin
            send_char(CH_DOT, 1'b0);
            repeat ($urandom_range(0, 3)) send_digit(1'b0);
        end
        if (early) send_digit(1'b1);
        else send_char($urandom_range(1) ? CH_SPACE : CH_SEMI, $urandom_range(3) == 0);
    endtask

    task automatic send_random_line();
        int pick;
        int which;
        pick = $urandom_range(99);
        if (pick < 60) begin
            send_axis_field();
        end else if (pick < 75) begin
            send_char(CH_Z, 1'b0);
            if ($urandom_range(3) == 0) send_char(CH_SPACE, 1'b0);
            send_char($urandom_range(1) ? CH_2 : CH_3, $urandom_range(3) == 0);
        end else if (pick < 88) begin
            send_char(8'($urandom_range(255)), $urandom_range(15) == 0);
        end else begin
            // broken fragments: stray markers and digits out of place
            which = $urandom_range(6);
            case (which)
                0: send_char(CH_DOT, $urandom_range(7) == 0);
                1: send_char(CH_Z, $urandom_range(7) == 0);
                2: send_char(CH_X, $urandom_range(7) == 0);
                3: send_char(CH_Y, $urandom_range(7) == 0);
                4: send_char(CH_SPACE, $urandom_range(7) == 0);
                5: send_char(CH_SEMI, $urandom_range(7) == 0);
                default: send_digit($urandom_range(7) == 0);
            endcase
        end
    endtask

    // Hold the sender until every due result has been taken, then let the pipe settle
    task automatic wait_drained();
        push <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_rate(logic [7:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        book.rate = v;
    endtask

    initial begin
        t_res got;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                got.kind = o_command_kind;
                got.neg = o_move_negative;
                got.steps = o_step_count;
                got.pen_down = o_pen_down;
                got.last = o_last_of_run;
                book.check_move(got);
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        logic [7:0] phase_rate [5];
        int start;
        book = new();
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_text_char <= 8'h00;
        i_end_of_text <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: saturation on both axes, round-up on x, negative move, pen across a
        // terminator, zero move, field cut by end of text, ignored bytes
        send_str("XY9999.9;", 1'b0);
        send_str("X0.4 ", 1'b0);
        send_str("Z 3", 1'b1);
        send_str("Z2", 1'b0);
        send_str("X;", 1'b0);
        send_str("Y7", 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        wait_drained();
        set_rate(8'd0);
        send_str("Y1;", 1'b0);
        wait_drained();

        phase_rate[0] = 8'd255;
        phase_rate[1] = 8'd1;
        phase_rate[2] = 8'($urandom_range(2, 254));
        phase_rate[3] = 8'($urandom_range(2, 254));
        phase_rate[4] = SPM_RESET;
        for (int p = 0; p < 5; p++) begin
            set_rate(phase_rate[p]);
            tx_idle_pct = (p == 2) ? 0 : 32;
            rx_idle_pct = (p == 2) ? 0 : 32;
            start = chars_sent;
            while (chars_sent - start < 190) send_random_line();
            wait_drained();
        end

        if (book.errors == 0) $display("gcode_xy_move_parser verification clean");
        else $display("gcode_xy_move_parser verification failed");
        $finish;
    end

endmodule
